[rtl/bdl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and ladder decode package
// Shared widths, the ladder threshold table and the ladder decode function.
// ----------------------------------------------------------------------------
package bdl_pkg;

    localparam int HISTORY_DEPTH = 10;
    localparam int PIN_W         = 3;
    localparam int ADC_W         = 8;
    localparam int KEY_N         = 10;
    localparam int OUT_W         = PIN_W + KEY_N;

    typedef logic [PIN_W-1:0] t_pins;
    typedef logic [ADC_W-1:0] t_adc;
    typedef logic [KEY_N-1:0] t_keys;
    typedef logic [OUT_W-1:0] t_buttons;

    // Lower bound of each band, from the no-key band downwards.
    localparam t_adc LADDER_BOUNDS [KEY_N] = '{
        8'd224, 8'd185, 8'd168, 8'd151, 8'd134,
        8'd117, 8'd99,  8'd82,  8'd67,  8'd48
    };

    function automatic t_keys decode_ladder(input t_adc sample);
        t_keys keys;
        keys    = '0;
        keys[0] = 1'b1;
        for (int k = KEY_N - 1; k >= 0; k--) begin
            if (sample >= LADDER_BOUNDS[k]) begin
                keys = '0;
                if (k != 0) begin
                    keys[KEY_N-k] = 1'b1;
                end
            end
        end
        return keys;
    endfunction

endpackage

[rtl/bdl_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Carries one beat of raw pin levels and one ladder ADC sample.
// ----------------------------------------------------------------------------
interface bdl_in_if;
    logic            valid;
    logic            ready;
    bdl_pkg::t_pins  pin_levels;
    bdl_pkg::t_adc   adc_sample;

    modport source (output valid, output pin_levels, output adc_sample, input ready);
    modport sink   (input valid, input pin_levels, input adc_sample, output ready);
endinterface

[rtl/bdl_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Carries one beat of held button state and this tick's press and release events.
// ----------------------------------------------------------------------------
interface bdl_out_if;
    logic               valid;
    logic               ready;
    bdl_pkg::t_buttons  button_state;
    bdl_pkg::t_buttons  pressed_events;
    bdl_pkg::t_buttons  released_events;

    modport source (output valid, output button_state, output pressed_events,
                    output released_events, input ready);
    modport sink   (input valid, input button_state, input pressed_events,
                    input released_events, output ready);
endinterface

[rtl/button_debounce_and_ladder_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce and ladder decode
// Debounces three active-low pins over a sample window and decodes a
// resistor-ladder keypad sample, reporting held state and edge events.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle unless stalled and returns exactly one
// result beat for each, in the next cycle, from an output register. A new beat is
// accepted whenever that register is empty or being emptied in the same cycle,
// so with the sink always ready the rate is one beat per cycle. The pin window
// is a chain of HISTORY_DEPTH-1 cells holding past samples; together with the
// incoming sample they make the full window, which starts cleared after reset.
module button_debounce_and_ladder_decode (
    input  logic i_clk,
    input  logic i_rst_n,
    bdl_in_if.sink    i_in,
    bdl_out_if.source o_out
);
    import bdl_pkg::*;

    localparam int CELLS = HISTORY_DEPTH - 1;

    logic  w_accept;
    t_pins w_pins;
    t_pins w_smp [CELLS+1];
    t_pins w_and [CELLS+1];
    t_pins w_all;
    t_keys w_keys;
    t_pins w_pin_chg;
    t_keys w_key_chg;

    t_pins    r_pins;
    t_keys    r_keys;
    logic     r_valid;
    t_buttons r_state;
    t_buttons r_pressed;
    t_buttons r_released;

    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_pins     = ~i_in.pin_levels;

    assign w_smp[0] = w_pins;
    assign w_and[0] = w_pins;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        bdl_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_accept),
            .i_sample (w_smp[g]),
            .i_and    (w_and[g]),
            .o_sample (w_smp[g+1]),
            .o_and    (w_and[g+1])
        );
    end

    assign w_all     = w_and[CELLS];
    assign w_keys    = decode_ladder(i_in.adc_sample);
    assign w_pin_chg = r_pins ^ w_all;
    assign w_key_chg = r_keys ^ w_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pins  <= '0;
            r_keys  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pins  <= w_all;
                r_keys  <= w_keys;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_state    <= {w_keys, w_all};
            r_pressed  <= {w_key_chg & w_keys, w_pin_chg & w_all};
            r_released <= {w_key_chg & ~w_keys, w_pin_chg & ~w_all};
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.button_state    = r_state;
    assign o_out.pressed_events  = r_pressed;
    assign o_out.released_events = r_released;

    a_one_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $onehot0(r_state[OUT_W-1:PIN_W]))
        else $error("more than one ladder key held");

    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_pressed & r_released) == '0))
        else $error("press and release on the same button");

    a_press_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (((r_pressed & ~r_state) == '0) && ((r_released & r_state) == '0)))
        else $error("event disagrees with held state");

    a_state_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_accept) |-> (r_state == {r_keys, r_pins}))
        else $error("output state differs from held state");

endmodule

[rtl/bdl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounce window cell
// Holds one past pin sample, passes it on when a beat is taken and folds it
// into the running AND that travels along the chain.
// ----------------------------------------------------------------------------
module bdl_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  bdl_pkg::t_pins i_sample,
    input  bdl_pkg::t_pins i_and,
    output bdl_pkg::t_pins o_sample,
    output bdl_pkg::t_pins o_and
);
    import bdl_pkg::*;

    t_pins r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;
    assign o_and    = i_and & r_sample;

endmodule
